### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define MMA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mma check failed");

// next-cycle implication, disabled while reset is active
`define MMA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mma check failed");

`endif

### src/mma_pkg.sv
`timescale 1ns / 1ps
package mma_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int IDX_W       = 6;
    localparam int DIM_W       = 5;
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    localparam logic [2:0] REQ_LOAD_A  = 3'd0;
    localparam logic [2:0] REQ_LOAD_B  = 3'd1;
    localparam logic [2:0] REQ_LOAD_C  = 3'd2;
    localparam logic [2:0] REQ_COMPUTE = 3'd3;
    localparam logic [2:0] REQ_READ_C  = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] element_value;
    } t_req;

    typedef struct packed {
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic signed [31:0] out_value;
    } t_res;

    // one A element travelling along the cell chain
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] kk;
        logic [31:0]      a;
    } t_tok;

    // host access shared by all cells
    typedef struct packed {
        logic             clr;
        logic             we_b;
        logic             we_c;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [31:0]      data;
    } t_host;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

### src/mma_cell.sv
`timescale 1ns / 1ps
module mma_cell #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF,
    parameter int J       = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mma_pkg::t_tok         i_tok,
    input  mma_pkg::t_host        i_host,
    input  logic [mma_pkg::IDX_W:0] i_n,
    output mma_pkg::t_tok         o_tok,
    output logic [31:0]           o_c_q
);
    import mma_pkg::*;

    localparam int RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // column J of B and of C
    logic [31:0] b_mem [MAX_DIM];
    logic [31:0] c_mem [MAX_DIM];

    t_tok        r_tok;
    t_tok        r_t1;
    t_tok        r_t2;
    logic [31:0] r_a1;
    logic [31:0] r_b_q;
    logic [31:0] r_c_q;
    logic [31:0] r_c2;
    logic [31:0] r_prod;
    logic [31:0] r_acc;

    logic [31:0]   w_prod;
    logic [31:0]   w_sum;
    logic          w_en;
    logic          w_c_we;
    logic [RW-1:0] w_c_addr;
    logic [31:0]   w_c_data;
    logic [RW-1:0] w_c_rd;

    // only the low word of the product is kept
    assign w_en   = J < int'(i_n);
    assign w_prod = r_a1 * r_b_q;
    assign w_sum  = (r_t2.first ? r_c2 : r_acc) + r_prod;
    assign w_c_rd = r_tok.valid ? r_tok.row[RW-1:0] : i_host.row[RW-1:0];

    always_comb begin
        w_c_we   = 1'b0;
        w_c_addr = i_host.row[RW-1:0];
        w_c_data = '0;
        priority if (i_host.clr) begin
            w_c_we = 1'b1;
        end else if (i_host.we_c && int'(i_host.col) == J) begin
            w_c_we   = 1'b1;
            w_c_data = i_host.data;
        end else if (r_t2.valid && r_t2.last && w_en) begin
            w_c_we   = 1'b1;
            w_c_addr = r_t2.row[RW-1:0];
            w_c_data = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_t1  <= '0;
            r_t2  <= '0;
        end else begin
            r_tok <= i_tok;
            r_t1  <= r_tok;
            r_t2  <= r_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_host.we_b && int'(i_host.col) == J) begin
            b_mem[i_host.row[RW-1:0]] <= i_host.data;
        end
        if (w_c_we) begin
            c_mem[w_c_addr] <= w_c_data;
        end
        r_b_q  <= b_mem[r_tok.kk[RW-1:0]];
        r_c_q  <= c_mem[w_c_rd];
        r_a1   <= r_tok.a;
        r_prod <= w_prod;
        r_c2   <= r_c_q;
        if (r_t2.valid) begin
            r_acc <= w_sum;
        end
    end

    assign o_tok = r_tok;
    assign o_c_q = r_c_q;

endmodule

### src/mma_seq.sv
`timescale 1ns / 1ps
module mma_seq #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [mma_pkg::DIM_W-1:0] i_dim,
    input  logic                      i_a_we,
    input  logic [mma_pkg::IDX_W-1:0] i_row,
    input  logic [mma_pkg::IDX_W-1:0] i_col,
    input  logic [31:0]               i_data,
    output logic                      o_busy,
    output logic                      o_clr,
    output logic [mma_pkg::IDX_W-1:0] o_clr_row,
    output logic [mma_pkg::IDX_W:0]   o_n,
    output mma_pkg::t_tok             o_tok
);
    import mma_pkg::*;

    localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DRAIN = MAX_DIM + 4;
    localparam int DW    = $clog2(DRAIN + 1);

    logic [31:0] a_mem [1 << (2 * RW)];

    t_state        r_state;
    t_state        n_state;
    logic [RW-1:0] r_i;
    logic [RW-1:0] r_k;
    logic [IDX_W:0] r_n;
    logic [DW-1:0] r_cnt;
    logic [RW-1:0] r_clr_row;
    t_tok          r_meta;
    logic [31:0]   r_a_q;

    logic           w_issue;
    logic           w_k_last;
    logic           w_i_last;
    logic [IDX_W:0] w_n_sat;

    // active dimension saturates at the store size
    assign w_n_sat  = (int'(i_dim) > MAX_DIM) ? (IDX_W+1)'(MAX_DIM) : (IDX_W+1)'(i_dim);
    assign w_k_last = int'(r_k) == int'(r_n) - 1;
    assign w_i_last = int'(r_i) == int'(r_n) - 1;

    always_comb begin
        n_state = r_state;
        w_issue = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (int'(r_clr_row) == MAX_DIM - 1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_go && w_n_sat != '0) n_state = ST_RUN;
            end
            ST_RUN: begin
                w_issue = 1'b1;
                if (w_k_last && w_i_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (int'(r_cnt) == DRAIN - 1) n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_row <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_n       <= '0;
            r_cnt     <= '0;
            r_meta    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_row <= r_clr_row + 1'b1;
            if (r_state == ST_IDLE) begin
                r_i   <= '0;
                r_k   <= '0;
                r_cnt <= '0;
                r_n   <= w_n_sat;
            end
            if (w_issue) begin
                if (w_k_last) begin
                    r_k <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (r_state == ST_DRAIN) r_cnt <= r_cnt + 1'b1;
            r_meta.valid <= w_issue;
            r_meta.first <= r_k == '0;
            r_meta.last  <= w_k_last;
            r_meta.row   <= IDX_W'(r_i);
            r_meta.kk    <= IDX_W'(r_k);
            r_meta.a     <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_a_we) begin
            a_mem[{i_row[RW-1:0], i_col[RW-1:0]}] <= i_data;
        end
        r_a_q <= a_mem[{r_i, r_k}];
    end

    always_comb begin
        o_tok   = r_meta;
        o_tok.a = r_a_q;
    end

    assign o_busy    = r_state != ST_IDLE;
    assign o_clr     = r_state == ST_CLEAR;
    assign o_clr_row = IDX_W'(r_clr_row);
    assign o_n       = r_n;

endmodule

### src/integer_matrix_multiply_accumulate_top.sv
`timescale 1ns / 1ps
// integer matrix multiply-accumulate, C += A*B over the active square
// request channel: a request is taken at a clock edge with start high and
// busy low; req_type selects load A, load B, load C, compute or read C
// loads do not raise busy and may follow back to back
// a read C request gives one result on o_result with o_result_valid high
// for exactly the next cycle; the receiver cannot stall it
// compute holds busy through a run phase, where one A element of the square
// of the saturated active dimension enters the cell chain per cycle, and a
// drain that covers the chain length plus the multiply-accumulate pipe
// the chain has one cell per column, each with its own multiplier and its
// own B and C column memories; A sits in a memory in the sequencer
// reset: active_dim returns to 16 and a clearing pass zeroes C, one row per
// cycle through all MAX_DIM rows, with busy high; config writes are still taken
// i_cfg_we writes active_dim; write it only while the block is idle
module integer_matrix_multiply_accumulate_top #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  mma_pkg::t_req             i_req,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [mma_pkg::DIM_W-1:0] i_cfg_data,
    output logic                      o_result_valid,
    output mma_pkg::t_res             o_result
);
    import mma_pkg::*;

    localparam int RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [DIM_W-1:0] r_dim;
    logic             r_rd_v;
    logic [3:0]       r_rd_row;
    logic [3:0]       r_rd_col;
    logic             r_rd_in;

    logic             w_acc;
    logic             w_inside;
    logic             w_clr;
    logic [IDX_W-1:0] w_clr_row;
    logic [IDX_W:0]   w_n;
    t_host            w_host;
    t_tok             w_seq_tok;
    t_tok             w_tok [MAX_DIM];
    logic [31:0]      w_c_q [MAX_DIM];

    assign w_acc    = start && !busy;
    assign w_inside = (int'(i_req.row_index) < MAX_DIM) && (int'(i_req.col_index) < MAX_DIM);

    // active dimension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_data;
        end
    end

    // shared host bus; the clearing pass borrows the row field
    always_comb begin
        w_host.clr  = w_clr;
        w_host.we_b = w_acc && w_inside && i_req.req_type == REQ_LOAD_B;
        w_host.we_c = w_acc && w_inside && i_req.req_type == REQ_LOAD_C;
        w_host.row  = w_clr ? w_clr_row : IDX_W'(i_req.row_index);
        w_host.col  = IDX_W'(i_req.col_index);
        w_host.data = i_req.element_value;
    end

    mma_seq #(.MAX_DIM(MAX_DIM)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_acc && i_req.req_type == REQ_COMPUTE),
        .i_dim     (r_dim),
        .i_a_we    (w_acc && w_inside && i_req.req_type == REQ_LOAD_A),
        .i_row     (IDX_W'(i_req.row_index)),
        .i_col     (IDX_W'(i_req.col_index)),
        .i_data    (i_req.element_value),
        .o_busy    (busy),
        .o_clr     (w_clr),
        .o_clr_row (w_clr_row),
        .o_n       (w_n),
        .o_tok     (w_seq_tok)
    );

    // one cell per column, A elements hop one cell per cycle
    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        mma_cell #(.MAX_DIM(MAX_DIM), .J(j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   ((j == 0) ? w_seq_tok : w_tok[(j == 0) ? 0 : j - 1]),
            .i_host  (w_host),
            .i_n     (w_n),
            .o_tok   (w_tok[j]),
            .o_c_q   (w_c_q[j])
        );
    end

    // read request: every cell reads the row, the column is picked next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= w_acc && i_req.req_type == REQ_READ_C;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= i_req.row_index;
        r_rd_col <= i_req.col_index;
        r_rd_in  <= w_inside;
    end

    assign o_result_valid     = r_rd_v;
    assign o_result.out_row   = r_rd_row;
    assign o_result.out_col   = r_rd_col;
    assign o_result.out_value = r_rd_in ? w_c_q[RW'(r_rd_col)] : '0;

endmodule

### src/mma_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mma_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input mma_pkg::t_req             i_req,
    input logic                      busy,
    input logic                      i_cfg_we,
    input logic [mma_pkg::DIM_W-1:0] i_cfg_data,
    input logic                      o_result_valid,
    input mma_pkg::t_res             o_result
);
    import mma_pkg::*;

    logic       w_rd_acc;
    logic       w_pos_ok;
    logic [3:0] r_req_row;
    logic [3:0] r_req_col;

    assign w_rd_acc = start && !busy && i_req.req_type == REQ_READ_C;

    // position of the request seen in the previous cycle
    always_ff @(posedge i_clk) begin
        r_req_row <= i_req.row_index;
        r_req_col <= i_req.col_index;
    end

    assign w_pos_ok = o_result.out_row == r_req_row && o_result.out_col == r_req_col;

    // a result only follows an accepted read
    `MMA_ASSERT_IMP(a_res_after_read, i_clk, i_rst_n, o_result_valid, $past(w_rd_acc))
    // an accepted read answers next cycle with its own position
    `MMA_ASSERT_NXT(a_read_answers, i_clk, i_rst_n, w_rd_acc, o_result_valid && w_pos_ok)
    // a read cannot start a compute, so busy stays low with its result
    `MMA_ASSERT_IMP(a_res_not_busy, i_clk, i_rst_n, o_result_valid, !busy)

endmodule

bind integer_matrix_multiply_accumulate_top mma_checker u_mma_checker (.*);

### bench/integer_matrix_multiply_accumulate_top_tb.sv
`timescale 1ns / 1ps
module integer_matrix_multiply_accumulate_top_tb;
    import mma_pkg::*;

    localparam int N_DIM       = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 185;

    typedef struct {
        t_req        req;
        bit          lit;
        logic [31:0] lit_value;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    t_req                 i_req = '0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 o_result_valid;
    t_res                 o_result;

    // mirror of the block: stores and active dimension
    logic [31:0] a_mem [N_DIM*N_DIM];
    logic [31:0] b_mem [N_DIM*N_DIM];
    logic [31:0] c_mem [N_DIM*N_DIM];
    logic [4:0]  mirror_dim;
    t_res        pending_reads [$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          tail_part = 1'b0;

    t_dir_row directed_rows [20] = '{
        '{'{REQ_READ_C,  4'd0,  4'd0,  32'h0},        1'b1, 32'h0},
        '{'{REQ_READ_C,  4'd15, 4'd15, 32'h0},        1'b1, 32'h0},
        '{'{REQ_LOAD_C,  4'd3,  4'd4,  32'h7fffffff}, 1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd3,  4'd4,  32'h0},        1'b1, 32'h7fffffff},
        '{'{REQ_LOAD_C,  4'd15, 4'd0,  32'h80000000}, 1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd15, 4'd0,  32'h0},        1'b1, 32'h80000000},
        '{'{REQ_LOAD_C,  4'd0,  4'd15, 32'hffffffff}, 1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd0,  4'd15, 32'h0},        1'b1, 32'hffffffff},
        '{'{REQ_LOAD_A,  4'd0,  4'd0,  32'hffffffff}, 1'b0, 32'h0},
        '{'{REQ_LOAD_B,  4'd0,  4'd0,  32'hffffffff}, 1'b0, 32'h0},
        '{'{REQ_LOAD_A,  4'd15, 4'd15, 32'h80000000}, 1'b0, 32'h0},
        '{'{REQ_LOAD_B,  4'd15, 4'd15, 32'h7fffffff}, 1'b0, 32'h0},
        // unused request codes are dropped silently
        '{'{3'd5,        4'd1,  4'd2,  32'h12345678}, 1'b0, 32'h0},
        '{'{3'd6,        4'd2,  4'd1,  32'h87654321}, 1'b0, 32'h0},
        '{'{3'd7,        4'd15, 4'd15, 32'hffffffff}, 1'b0, 32'h0},
        '{'{REQ_COMPUTE, 4'd0,  4'd0,  32'h0},        1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd0,  4'd0,  32'h0},        1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd15, 4'd15, 32'h0},        1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd3,  4'd4,  32'h0},        1'b0, 32'h0},
        '{'{REQ_READ_C,  4'd15, 4'd0,  32'h0},        1'b0, 32'h0}
    };

    integer_matrix_multiply_accumulate_top #(.MAX_DIM(N_DIM)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req          (i_req),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #6 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // c += a*b over the leading square, wrapping at 32 bits
    task automatic mac_update();
        int          n;
        logic [31:0] acc;
        n = (mirror_dim > N_DIM) ? N_DIM : int'(mirror_dim);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = c_mem[i*N_DIM + j];
                for (int k = 0; k < n; k++)
                    acc = acc + 32'(a_mem[i*N_DIM + k] * b_mem[k*N_DIM + j]);
                c_mem[i*N_DIM + j] = acc;
            end
        end
    endtask

    // apply one accepted request to the mirror, queue the read result
    task automatic mirror_request(t_req r, bit lit, logic [31:0] lit_value);
        int   addr;
        t_res res;
        addr = int'(r.row_index) * N_DIM + int'(r.col_index);
        case (r.req_type)
            REQ_LOAD_A:  a_mem[addr] = r.element_value;
            REQ_LOAD_B:  b_mem[addr] = r.element_value;
            REQ_LOAD_C:  c_mem[addr] = r.element_value;
            REQ_COMPUTE: mac_update();
            REQ_READ_C: begin
                res.out_row   = r.row_index;
                res.out_col   = r.col_index;
                res.out_value = lit ? lit_value : c_mem[addr];
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endtask

    // drive at negedge, hold until a rising edge sees start with busy low
    task automatic send_request(t_req r, bit lit, logic [31:0] lit_value);
        if (!tail_part && $urandom_range(0, 9) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = r;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        mirror_request(r, lit, lit_value);
        @(negedge i_clk);
    endtask

    task automatic write_dim(logic [4:0] d);
        start = 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        mirror_dim = d;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // mostly loads and reads inside the active square, a few computes
    function automatic t_req make_request();
        t_req r;
        int   u, n;
        u = $urandom_range(0, 99);
        n = (mirror_dim > N_DIM) ? N_DIM : int'(mirror_dim);
        if (u < 28)      r.req_type = REQ_LOAD_A;
        else if (u < 54) r.req_type = REQ_LOAD_B;
        else if (u < 64) r.req_type = REQ_LOAD_C;
        else if (u < 68) r.req_type = REQ_COMPUTE;
        else if (u < 97) r.req_type = REQ_READ_C;
        else             r.req_type = 3'($urandom_range(5, 7));
        if (n > 0 && $urandom_range(0, 9) < 7) begin
            r.row_index = 4'($urandom_range(0, n-1));
            r.col_index = 4'($urandom_range(0, n-1));
        end else begin
            r.row_index = 4'($urandom_range(0, 15));
            r.col_index = 4'($urandom_range(0, 15));
        end
        r.element_value = pick_value();
        return r;
    endfunction

    // each result lives one cycle; compare with the oldest pending read
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected result row/col",
                                32'({o_result.out_row, o_result.out_col}), 32'h0);
            end else begin
                t_res want;
                want = pending_reads.pop_front();
                if (o_result.out_row !== want.out_row)
                    report_mismatch("out_row", 32'(o_result.out_row), 32'(want.out_row));
                if (o_result.out_col !== want.out_col)
                    report_mismatch("out_col", 32'(o_result.out_col), 32'(want.out_col));
                if (o_result.out_value !== want.out_value)
                    report_mismatch("out_value", o_result.out_value, want.out_value);
            end
        end
    end

    initial begin
        t_req        r;
        logic [4:0]  phase_dim;
        int          settle;
        for (int i = 0; i < N_DIM*N_DIM; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
        end
        mirror_dim = DIM_RESET;

        // hold synchronous reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill A and B completely so no compute touches an unwritten entry
        for (int i = 0; i < N_DIM*N_DIM; i++) begin
            r = '{REQ_LOAD_A, 4'(i / N_DIM), 4'(i % N_DIM), pick_value()};
            send_request(r, 1'b0, '0);
            r = '{REQ_LOAD_B, 4'(i / N_DIM), 4'(i % N_DIM), pick_value()};
            send_request(r, 1'b0, '0);
        end

        // directed table at the reset dimension of 16
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].lit,
                         directed_rows[i].lit_value);

        // random phases over several dimensions: smallest, saturating,
        // zero, full, two, then random
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: phase_dim = 5'd1;
                1: phase_dim = 5'd31;
                2: phase_dim = 5'd0;
                3: phase_dim = 5'd16;
                4: phase_dim = 5'd2;
                default: phase_dim = 5'($urandom_range(1, 8));
            endcase
            write_dim(phase_dim);
            if (p == RAND_PHASES - 1)
                tail_part = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(make_request(), 1'b0, '0);
        end

        start = 1'b0;
        settle = 0;
        while (pending_reads.size() != 0 && settle < 5000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (N_DIM*N_DIM + N_DIM + 8) @(posedge i_clk);
        if (err_count == 0 && pending_reads.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
